/* rtl/sort_by_even_place_digit_sum_top_defines.svh */
// Assertion macros for the even-place digit sum sorter.
`ifndef SORT_BY_EVEN_PLACE_DIGIT_SUM_TOP_DEFINES_SVH
`define SORT_BY_EVEN_PLACE_DIGIT_SUM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SEPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SEPS_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define SEPS_ASSERT(label, cond, msg)
`define SEPS_ASSERT_IMP(label, pre, post, msg)
`endif
`endif

/* rtl/seps_pkg.sv */
// Shared types and constants for the even-place digit sum sorter.
package seps_pkg;
  localparam int DEPTH_DEF  = 64;
  localparam int DIGITS_DEF = 7;
  localparam int VAL_W      = 24;
  localparam int KEY_W      = 5;
  localparam logic [KEY_W-1:0] KEY_MAX = 5'd31;

  // one classified request from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    logic             is_last;
  } item_t;
endpackage

/* rtl/seps_front.sv */
// Front: saturate a value and form its key one digit per cycle.
module seps_front #(
  parameter int DIGITS = seps_pkg::DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [seps_pkg::VAL_W-1:0] in_value,
  input  logic                      in_is_last,
  output logic                      q_push,
  input  logic                      q_full,
  output seps_pkg::item_t           q_item
);
  import seps_pkg::*;
  localparam logic [63:0] LIM64 = (64'd10 ** DIGITS) - 64'd1;
  localparam logic [VAL_W-1:0] LIM =
    (LIM64 > 64'hFFFFFF) ? 24'hFFFFFF : LIM64[VAL_W-1:0];

  typedef enum logic [2:0] {S_IDLE = 3'b001, S_DIG = 3'b010, S_OUT = 3'b100} st_t;
  st_t st_r, st_nxt;
  logic [VAL_W-1:0] val_r, rem_r;
  logic [VAL_W-1:0] val_nxt, rem_nxt;
  logic [7:0] odd_r, even_r, odd_nxt, even_nxt;
  logic par_r, par_nxt, last_r, last_nxt;
  logic [VAL_W-1:0] quo;
  logic [3:0] dig;
  logic [VAL_W+5:0] prod;
  logic [7:0] sum;

  // divide by ten: reciprocal multiply rounded down, then one upward correction
  always_comb begin
    logic [VAL_W+24:0] m;
    m    = {25'd0, rem_r} * 49'd3355443;
    quo  = m[VAL_W+24:25];
    prod = {6'd0, quo} * 30'd10;
    if (rem_r - prod[VAL_W-1:0] >= 24'd10) begin
      quo = quo + 24'd1;
    end
    dig = 4'(rem_r - quo * 24'd10);
  end

  always_comb begin
    st_nxt = st_r; val_nxt = val_r; rem_nxt = rem_r;
    odd_nxt = odd_r; even_nxt = even_r; par_nxt = par_r; last_nxt = last_r;
    case (st_r)
      S_IDLE: begin
        if (in_push) begin
          val_nxt = (in_value > LIM) ? LIM : in_value;
          rem_nxt = val_nxt;
          odd_nxt = '0; even_nxt = '0; par_nxt = 1'b0;
          last_nxt = in_is_last;
          st_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (rem_r == '0) begin
          st_nxt = S_OUT;
        end else begin
          // par_r low: this digit has an odd place counting from the bottom
          if (!par_r) odd_nxt = odd_r + 8'(dig);
          else        even_nxt = even_r + 8'(dig);
          par_nxt = ~par_r;
          rem_nxt = quo;
        end
      end
      S_OUT: if (!q_full) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    val_r <= val_nxt; rem_r <= rem_nxt; odd_r <= odd_nxt; even_r <= even_nxt;
    par_r <= par_nxt; last_r <= last_nxt;
  end

  // par_r high after an odd digit count: top even places are bottom even places
  assign sum = par_r ? even_r : odd_r;
  assign in_full = (st_r != S_IDLE);
  assign q_push = (st_r == S_OUT);
  assign q_item.value = val_r;
  assign q_item.key = (sum > 8'(KEY_MAX)) ? KEY_MAX : sum[KEY_W-1:0];
  assign q_item.is_last = last_r;
endmodule

/* rtl/seps_queue.sv */
// Two-entry queue between front and back.
module seps_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            w_push,
  output logic            w_full,
  input  seps_pkg::item_t w_item,
  input  logic            r_pop,
  output logic            r_empty,
  output seps_pkg::item_t r_item
);
  import seps_pkg::*;
  item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr = w_push && !w_full;
  assign rd = r_pop && !r_empty;
  assign w_full = (cnt_r == 2'd2);
  assign r_empty = (cnt_r == 2'd0);
  assign r_item = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= w_item;
  end
endmodule

/* rtl/seps_back.sv */
// Back: store items, then scan the store once per key to emit in order.
module seps_back #(
  parameter int DEPTH = seps_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  seps_pkg::item_t            q_item,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [seps_pkg::VAL_W-1:0] out_sorted_value,
  output logic                       out_end_of_run,
  output logic                       out_overflowed
);
  import seps_pkg::*;
  `include "sort_by_even_place_digit_sum_top_defines.svh"
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {S_LOAD = 3'b001, S_SCAN = 3'b010, S_DONE = 3'b100} st_t;
  st_t st_r;
  logic [VAL_W-1:0] vmem [DEPTH];
  logic [KEY_W-1:0] kmem [DEPTH];
  logic [CW-1:0] fill_r, idx_r, emit_r;
  logic [KEY_W-1:0] key_r;
  logic ovf_r;
  // registered read of the entry at idx_r - 1
  logic [VAL_W-1:0] rv_r;
  logic [KEY_W-1:0] rk_r;
  logic rvalid_r;
  logic [VAL_W-1:0] ov_r;
  logic oe_r, oo_r, ofull_r;
  logic take, hit, rd_en, hold;

  assign hold = ofull_r && !out_pop;
  assign q_pop = (st_r == S_LOAD) && !q_empty;
  assign take = q_pop && (fill_r != CW'(DEPTH));
  assign hit = rvalid_r && (rk_r == key_r);
  assign rd_en = (st_r == S_SCAN) && !hold && (idx_r < fill_r);

  always_ff @(posedge clk) begin
    if (take) begin
      vmem[fill_r[AW-1:0]] <= q_item.value;
      kmem[fill_r[AW-1:0]] <= q_item.key;
    end
    if (rd_en) begin
      rv_r <= vmem[idx_r[AW-1:0]];
      rk_r <= kmem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; fill_r <= '0; ovf_r <= 1'b0; idx_r <= '0; key_r <= '0;
      emit_r <= '0; rvalid_r <= 1'b0; ofull_r <= 1'b0;
    end else begin
      if ((st_r == S_SCAN) && hit && !hold) ofull_r <= 1'b1;
      else if (out_pop) ofull_r <= 1'b0;
      case (st_r)
        S_LOAD: begin
          if (q_pop) begin
            if (take) fill_r <= fill_r + CW'(1);
            else      ovf_r <= 1'b1;
            if (q_item.is_last) begin
              st_r <= S_SCAN; idx_r <= '0; key_r <= '0; emit_r <= '0;
              rvalid_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (!hold) begin
            rvalid_r <= rd_en;
            if (hit) begin
              ov_r <= rv_r;
              oe_r <= (emit_r + CW'(1) == fill_r);
              oo_r <= ovf_r;
              emit_r <= emit_r + CW'(1);
            end
            if (rd_en) begin
              idx_r <= idx_r + CW'(1);
            end else if (!rvalid_r || idx_r == fill_r) begin
              // pass over: next key, or finish
              if (key_r == KEY_MAX || (emit_r + CW'(hit)) == fill_r) begin
                st_r <= S_DONE;
              end else begin
                key_r <= key_r + KEY_W'(1);
                idx_r <= '0;
              end
            end
          end
        end
        S_DONE: begin
          if (!ofull_r || out_pop) begin
            st_r <= S_LOAD; fill_r <= '0; ovf_r <= 1'b0; emit_r <= '0;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign out_empty = !ofull_r;
  assign out_sorted_value = ov_r;
  assign out_end_of_run = oe_r;
  assign out_overflowed = oo_r;

  `SEPS_ASSERT(a_fill_bound, fill_r <= CW'(DEPTH), "fill count beyond depth")
  `SEPS_ASSERT(a_emit_bound, emit_r <= fill_r, "emitted more than stored")
  `SEPS_ASSERT_IMP(a_no_pop_scan, st_r == S_SCAN, !q_pop || st_r != S_SCAN, "pop while scanning")
endmodule

/* rtl/sort_by_even_place_digit_sum_top.sv */
// Top level of the even-place digit sum sorter.
// Each key is formed by the one-digit-per-cycle key unit in the front, which
// takes no new value until that key is queued. After the item marked last, the
// back scans its store once per key value from 0 up, one entry per cycle on
// the single read port unless the output is held, stopping when every stored
// value has left: up to 32 passes. Results leave in ascending key, ties in
// arrival order; a full store drops further items and flags every batch result.
module sort_by_even_place_digit_sum_top #(
  parameter int DEPTH  = seps_pkg::DEPTH_DEF,
  parameter int DIGITS = seps_pkg::DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [seps_pkg::VAL_W-1:0] in_value,
  input  logic                       in_is_last,
  output logic                       empty,
  input  logic                       pop,
  output logic [seps_pkg::VAL_W-1:0] out_sorted_value,
  output logic                       out_end_of_run,
  output logic                       out_overflowed
);
  import seps_pkg::*;
  logic f_push, f_full, b_pop, b_empty;
  item_t f_item, b_item;

  seps_front #(.DIGITS(DIGITS)) u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_value, .in_is_last,
    .q_push(f_push), .q_full(f_full), .q_item(f_item));
  seps_queue u_queue (
    .clk, .rst_n, .w_push(f_push), .w_full(f_full), .w_item(f_item),
    .r_pop(b_pop), .r_empty(b_empty), .r_item(b_item));
  seps_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst_n, .q_empty(b_empty), .q_pop(b_pop), .q_item(b_item),
    .out_empty(empty), .out_pop(pop), .out_sorted_value, .out_end_of_run,
    .out_overflowed);
endmodule
